// ===== design/aging_life_grid_generation_step_defines.svh =====
`ifndef AGING_LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define AGING_LIFE_GRID_GENERATION_STEP_DEFINES_SVH

// Same-cycle implication, off while reset is active
`define ALGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is active
`define ALGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/algs_pkg.sv =====
package algs_pkg;

	// Largest grid side and stored age width
	localparam int MAX_GRID  = 32;
	localparam int AGE_BITS  = 8;

	// Fixed port widths and the grid side after reset
	localparam int SIZE_W    = 6;
	localparam int PORT_AGE_W = 8;
	localparam int GRID_RESET = 32;

	// Position counters: rows run two past the grid while the window drains
	localparam int COL_W  = $clog2(MAX_GRID);
	localparam int ROW_W  = $clog2(MAX_GRID + 2);
	localparam int WIDE_W = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;

	// Neighbor count and the live range that keeps a cell going
	localparam int CNT_W        = 4;
	localparam int SURVIVE_MIN  = 2;
	localparam int SURVIVE_MAX  = 3;

	typedef logic [AGE_BITS-1:0]   age_t;
	typedef logic [PORT_AGE_W-1:0] port_age_t;

	localparam age_t AGE_MAX = '1;

	// One column of the window: [0] top, [1] middle, [2] bottom
	typedef age_t [2:0] column_t;
	// Window: [0] left, [1] center, [2] right column
	typedef column_t [2:0] window_t;

	// Window edges that lie outside the grid
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} edge_t;

	// Line store entry: ages of the same column two rows and one row back
	typedef struct packed {
		age_t older;
		age_t newer;
	} line_entry_t;

endpackage

// ===== design/algs_rule.sv =====
module algs_rule (
	input  algs_pkg::window_t win,
	input  algs_pkg::edge_t   dead,
	output algs_pkg::age_t    next_age
);
	import algs_pkg::*;

	logic [CNT_W-1:0] live_cnt;
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	age_t             center;
	logic             survive;

	// Count live neighbors that lie inside the grid
	always_comb begin
		row_ok = {~dead.bottom, 1'b1, ~dead.top};
		col_ok = {~dead.right, 1'b1, ~dead.left};
		live_cnt = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c] && (win[c][r] != '0)) begin
					live_cnt = live_cnt + CNT_W'(1);
				end
			end
		end
	end

	// Age rule: survive or birth ages by one, saturating; otherwise die
	assign center  = win[1][1];
	assign survive = (live_cnt >= CNT_W'(SURVIVE_MIN)) && (live_cnt <= CNT_W'(SURVIVE_MAX));

	always_comb begin
		if (!survive) begin
			next_age = '0;
		end else if (center == AGE_MAX) begin
			next_age = AGE_MAX;
		end else begin
			next_age = center + age_t'(1);
		end
	end

endmodule

// ===== design/aging_life_grid_generation_step.sv =====
// One generation of an aging life grid (B23/S23 style with 2 or 3 neighbors
// keeping or starting a cell, age counting up to 255). Cell ages of a square
// grid of side grid_size (0 acts as 1, above 32 acts as 32) are taken one per
// clock while in_ready is high, in raster order; next-generation ages leave in
// raster order through a valid/ready output register, the final cell flagged
// by last_of_grid. Two line stores of one row each and a 3x3 window give every
// cell its neighborhood; the result for cell p is formed when input
// p+grid_size+1 is in stage 1 and is then registered. After the last cell of a
// grid the input stays not ready while grid_size+1 drain items pass the last
// row through the window. A write to grid_size restarts the grid at its first
// cell; the user makes it only while idle, which the block does not enforce.
module aging_life_grid_generation_step (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       grid_size_we,
	input  logic [5:0] grid_size,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] cell_age,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] next_age,
	output logic       last_of_grid
);
	import algs_pkg::*;

	// Configuration and position of the next item into the stage
	logic [SIZE_W-1:0] grid_q;
	logic [SIZE_W-1:0] g;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              flush_q;

	// Stage 1: item being processed
	logic              valid_s1;
	age_t              age_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic              last_s1;
	line_entry_t       ent_s1;

	// Window, line store, result register
	column_t           win_l_q;
	column_t           win_m_q;
	line_entry_t       line_q [MAX_GRID];
	logic              out_valid_q;
	age_t              out_age_q;
	logic              out_last_q;

	logic [WIDE_W-1:0] g_w;
	logic [WIDE_W-1:0] row_w;
	logic [WIDE_W-1:0] row_s1_w;
	logic              col_wrap;
	logic              grid_end;
	logic              flush_end;
	logic              s1_free;
	logic              load;
	age_t              load_age;
	logic              first_col;
	logic              emit;
	logic              out_free;
	logic              adv;
	column_t           new_col;
	window_t           win;
	edge_t             dead;
	age_t              rule_age;

	// Clamp the configured side
	always_comb begin
		if (grid_q == '0) begin
			g = SIZE_W'(1);
		end else if (grid_q > SIZE_W'(MAX_GRID)) begin
			g = SIZE_W'(MAX_GRID);
		end else begin
			g = grid_q;
		end
	end

	assign g_w      = WIDE_W'(g);
	assign row_w    = WIDE_W'(row_q);
	assign row_s1_w = WIDE_W'(row_s1);

	// Position sequencing: real cells, then one drain row plus one cell
	assign col_wrap  = (SIZE_W'(col_q) + SIZE_W'(1)) == g;
	assign grid_end  = !flush_q && col_wrap && (row_w == g_w - WIDE_W'(1));
	assign flush_end = flush_q && (row_w == g_w + WIDE_W'(1));

	// Input handshake: drain items take priority over new cells
	assign s1_free  = !valid_s1 || adv;
	assign in_ready = s1_free && !flush_q;
	assign load     = s1_free && (flush_q || in_valid);
	assign load_age = flush_q ? '0 : age_t'(cell_age);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q  <= SIZE_W'(GRID_RESET);
			row_q   <= '0;
			col_q   <= '0;
			flush_q <= 1'b0;
		end else if (grid_size_we) begin
			grid_q  <= grid_size;
			row_q   <= '0;
			col_q   <= '0;
			flush_q <= 1'b0;
		end else if (load) begin
			if (flush_end) begin
				row_q   <= '0;
				col_q   <= '0;
				flush_q <= 1'b0;
			end else if (col_wrap) begin
				row_q <= row_q + ROW_W'(1);
				col_q <= '0;
				if (grid_end) begin
					flush_q <= 1'b1;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Line store read with the item; a one-column grid takes the entry being written
	always_ff @(posedge clk) begin
		if (load) begin
			age_s1  <= load_age;
			row_s1  <= row_q;
			col_s1  <= col_q;
			last_s1 <= flush_end;
			if (adv && (col_q == col_s1)) begin
				ent_s1 <= '{older: ent_s1.newer, newer: age_s1};
			end else begin
				ent_s1 <= line_q[col_q];
			end
		end
	end

	// Center is one row up and one column left; in column 0 it is the
	// last cell of the row two up, with the right column off the grid
	assign first_col = (col_s1 == '0);
	assign emit      = valid_s1 && (first_col ? (row_s1_w >= WIDE_W'(2))
	                                          : (row_s1_w >= WIDE_W'(1)));
	assign out_free  = !out_valid_q || out_ready;
	assign adv       = valid_s1 && (!emit || out_free);

	// Window assembly from line store and incoming cell
	assign new_col[0] = ent_s1.older;
	assign new_col[1] = ent_s1.newer;
	assign new_col[2] = age_s1;
	assign win[0]     = win_l_q;
	assign win[1]     = win_m_q;
	assign win[2]     = new_col;

	assign dead.top    = first_col ? (row_s1_w == WIDE_W'(2)) : (row_s1_w == WIDE_W'(1));
	assign dead.bottom = first_col ? (row_s1_w == g_w + WIDE_W'(1)) : (row_s1_w == g_w);
	assign dead.left   = first_col ? (g == SIZE_W'(1)) : (col_s1 == COL_W'(1));
	assign dead.right  = first_col;

	algs_rule u_rule (
		.win      (win),
		.dead     (dead),
		.next_age (rule_age)
	);

	// Window shift and line store update
	always_ff @(posedge clk) begin
		if (adv) begin
			win_l_q        <= win_m_q;
			win_m_q        <= new_col;
			line_q[col_s1] <= '{older: ent_s1.newer, newer: age_s1};
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_age_q  <= rule_age;
			out_last_q <= last_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_age     = port_age_t'(out_age_q);
	assign last_of_grid = out_last_q;

endmodule

// ===== design/algs_checker.sv =====
`include "aging_life_grid_generation_step_defines.svh"

module algs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] next_age,
	input logic       last_of_grid
);

	// A stalled result holds its payload
	`ALGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(next_age) && $stable(last_of_grid), "stalled result changed")

	// A result leaves only when it is taken
	`ALGS_ASSERT_NOW(a_no_drop, clk, arst_n, $fell(out_valid), $past(out_ready), "result dropped")

	// Out of reset: empty result register, input open
	`ALGS_ASSERT_NOW(a_reset_state, clk, arst_n, !$past(arst_n), in_ready && !out_valid, "bad state after reset")

endmodule

bind aging_life_grid_generation_step algs_checker u_algs_checker (.*);
